// ===== src/quaternion_world_accel_magnitude_macros.svh =====
// ----------------------------------------------------------------------------
// quaternion_world_accel_magnitude_macros
// Assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_WORLD_ACCEL_MAGNITUDE_MACROS_SVH
`define QUATERNION_WORLD_ACCEL_MAGNITUDE_MACROS_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low.
`define QWAM_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is checked after a delay set by n.
`define QWAM_ASSERT_DLY(label, ante, n, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##(n) (cons)) \
		else $error(msg);

`endif

// ===== src/qwam_pkg.sv =====
// ----------------------------------------------------------------------------
// qwam_pkg
// Item types, lane types and fixed constants of the world-frame accel block.
// ----------------------------------------------------------------------------
package qwam_pkg;

	typedef struct packed {
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
	} in_t;

	typedef struct packed {
		logic signed [15:0] world_x_mg;
		logic signed [15:0] world_y_mg;
		logic signed [15:0] world_z_mg;
		logic        [7:0]  magnitude_tenths_g;
	} out_t;

	typedef struct packed {
		logic signed [15:0] world_x_mg;
		logic signed [15:0] world_y_mg;
		logic signed [15:0] world_z_mg;
	} world_t;

	localparam int Q14_BITS  = 14;
	localparam int DIV_QBITS = 17;
	localparam int ROOT_W    = 16;
	localparam int RAD_W     = 2 * ROOT_W;

	// one divider lane: sign, quotient overflow, partial remainder and
	// dividend bits still to go (quotient bits shift in from the bottom)
	typedef struct packed {
		logic                 neg;
		logic                 ovf;
		logic [15:0]          rem;
		logic [DIV_QBITS-1:0] low;
	} div_lane_t;

	typedef struct packed {
		logic [RAD_W-1:0] rad;
		logic             big;
		world_t           world;
	} mag_in_t;

	typedef struct packed {
		logic [ROOT_W-1:0] root;
		logic              big;
		world_t            world;
	} mag_out_t;

	localparam logic [15:0] LSB_RESET   = 16'd2048;
	localparam int          MG_PER_G    = 1000;
	localparam int          LANE_Z      = 2;
	localparam int          MAG_SAT_MG  = 25450;
	localparam int          TENTHS_HALF = 50;
	localparam int          RECIP_100   = 83887;
	localparam int          RECIP_SHIFT = 23;
	localparam logic [7:0]  TENTHS_MAX  = 8'd255;

	localparam int ROT_STAGES  = 6;
	localparam int DIV_STAGES  = DIV_QBITS;
	localparam int POST_STAGES = 4;
	localparam int SQRT_STAGES = ROOT_W;
	localparam int LATENCY     = ROT_STAGES + DIV_STAGES + POST_STAGES + SQRT_STAGES + 1;

endpackage

// ===== src/qwam_rot.sv =====
// ----------------------------------------------------------------------------
// qwam_rot
// Rotation matrix from the quaternion, matrix times sample, rounding to Q14
// counts and scaling to the mg dividend for the divider lanes.
// ----------------------------------------------------------------------------
module qwam_rot #(
	parameter int QUAT_FRAC_BITS = 14
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  qwam_pkg::in_t             in_item,
	input  logic [15:0]               lsb,
	output logic                      out_valid,
	output qwam_pkg::div_lane_t [2:0] lanes
);
	import qwam_pkg::*;

	localparam int FB2 = 2 * QUAT_FRAC_BITS;
	localparam int EW  = (FB2 + 2 > 35) ? FB2 + 2 : 35;
	localparam int TW  = EW + 16;
	localparam int SW  = EW + 18;
	localparam int SW1 = SW + 1;
	localparam int SH  = FB2 - Q14_BITS;
	localparam int QMW = SW1 - SH;
	localparam int AW  = QMW + 11;
	localparam int HB  = Q14_BITS + DIV_QBITS;
	localparam int HW  = AW - HB;
	localparam int CW  = (HW > 16) ? HW : 16;

	localparam logic signed [EW-1:0] ONE  = EW'(1) <<< FB2;
	localparam logic [SW:0]          HALF = SW1'(1) << (SH - 1);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic signed [31:0] xx_s1, yy_s1, zz_s1, xy_s1, zw_s1, xz_s1, yw_s1, yz_s1, xw_s1;
	logic signed [15:0] a_s1 [3];
	logic signed [EW-1:0] m_s2 [3][3];
	logic signed [15:0] a_s2 [3];
	logic signed [TW-1:0] t_s3 [3][3];
	logic signed [SW-1:0] s_s4 [3];
	logic neg_s5 [3];
	logic [QMW-1:0] mag_s5 [3];
	div_lane_t [2:0] lanes_s6;

	logic [SW-1:0] fold [3];
	logic [SW:0] rsum [3];
	logic [AW-1:0] scaled [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// quaternion products
	always_ff @(posedge clk) begin
		xx_s1 <= 32'(in_item.quat_x) * 32'(in_item.quat_x);
		yy_s1 <= 32'(in_item.quat_y) * 32'(in_item.quat_y);
		zz_s1 <= 32'(in_item.quat_z) * 32'(in_item.quat_z);
		xy_s1 <= 32'(in_item.quat_x) * 32'(in_item.quat_y);
		zw_s1 <= 32'(in_item.quat_z) * 32'(in_item.quat_w);
		xz_s1 <= 32'(in_item.quat_x) * 32'(in_item.quat_z);
		yw_s1 <= 32'(in_item.quat_y) * 32'(in_item.quat_w);
		yz_s1 <= 32'(in_item.quat_y) * 32'(in_item.quat_z);
		xw_s1 <= 32'(in_item.quat_x) * 32'(in_item.quat_w);
		a_s1[0] <= in_item.accel_x;
		a_s1[1] <= in_item.accel_y;
		a_s1[2] <= in_item.accel_z;
	end

	// matrix entries in Q(2F)
	always_ff @(posedge clk) begin
		m_s2[0][0] <= ONE - ((EW'(yy_s1) + EW'(zz_s1)) <<< 1);
		m_s2[0][1] <= (EW'(xy_s1) - EW'(zw_s1)) <<< 1;
		m_s2[0][2] <= (EW'(xz_s1) + EW'(yw_s1)) <<< 1;
		m_s2[1][0] <= (EW'(xy_s1) + EW'(zw_s1)) <<< 1;
		m_s2[1][1] <= ONE - ((EW'(xx_s1) + EW'(zz_s1)) <<< 1);
		m_s2[1][2] <= (EW'(yz_s1) - EW'(xw_s1)) <<< 1;
		m_s2[2][0] <= (EW'(xz_s1) - EW'(yw_s1)) <<< 1;
		m_s2[2][1] <= (EW'(yz_s1) + EW'(xw_s1)) <<< 1;
		m_s2[2][2] <= ONE - ((EW'(xx_s1) + EW'(yy_s1)) <<< 1);
		a_s2 <= a_s1;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				t_s3[i][j] <= TW'(m_s2[i][j]) * TW'(a_s2[j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			s_s4[i] <= SW'(t_s3[i][0]) + SW'(t_s3[i][1]) + SW'(t_s3[i][2]);
		end
	end

	// round half away from zero to Q14 counts, as sign and magnitude;
	// for negatives ~s + 1 is |s|, folded into the rounding constant
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			fold[i] = s_s4[i][SW-1] ? ~s_s4[i] : s_s4[i];
			rsum[i] = SW1'(fold[i]) + (s_s4[i][SW-1] ? HALF + SW1'(1) : HALF);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			neg_s5[i] <= s_s4[i][SW-1];
			mag_s5[i] <= rsum[i][SW:SH];
		end
	end

	// dividend: floor((|q14| * 1000 + lsb * 2^13) / 2^14), split for the divider
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			scaled[i] = AW'(mag_s5[i]) * AW'(MG_PER_G) + (AW'(lsb) << (Q14_BITS - 1));
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			lanes_s6[i].neg <= neg_s5[i];
			lanes_s6[i].ovf <= CW'(scaled[i][AW-1:HB]) >= CW'(lsb);
			lanes_s6[i].rem <= 16'(scaled[i][AW-1:HB]);
			lanes_s6[i].low <= scaled[i][HB-1:Q14_BITS];
		end
	end

	assign out_valid = v_s6;
	assign lanes     = lanes_s6;

endmodule

// ===== src/qwam_div.sv =====
// ----------------------------------------------------------------------------
// qwam_div
// Pipelined restoring divider, three lanes by the common scale, one quotient
// bit per stage.
// ----------------------------------------------------------------------------
module qwam_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [15:0]               lsb,
	input  qwam_pkg::div_lane_t [2:0] in_lanes,
	output logic                      out_valid,
	output qwam_pkg::div_lane_t [2:0] out_lanes
);
	import qwam_pkg::*;

	logic [DIV_STAGES-1:0] v_s;
	div_lane_t [2:0] lane_s [DIV_STAGES];

	function automatic div_lane_t div_step(input div_lane_t l, input logic [15:0] d);
		logic [16:0] r;
		logic        ge;
		logic [16:0] diff;
		div_lane_t   o;
		r    = {l.rem, l.low[DIV_QBITS-1]};
		ge   = r >= {1'b0, d};
		diff = r - {1'b0, d};
		o     = l;
		o.rem = ge ? diff[15:0] : r[15:0];
		o.low = {l.low[DIV_QBITS-2:0], ge};
		return o;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			v_s <= {v_s[DIV_STAGES-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			lane_s[0][i] <= div_step(in_lanes[i], lsb);
		end
		for (int k = 1; k < DIV_STAGES; k++) begin
			for (int i = 0; i < 3; i++) begin
				lane_s[k][i] <= div_step(lane_s[k-1][i], lsb);
			end
		end
	end

	assign out_valid = v_s[DIV_STAGES-1];
	assign out_lanes = lane_s[DIV_STAGES-1];

endmodule

// ===== src/qwam_sqrt.sv =====
// ----------------------------------------------------------------------------
// qwam_sqrt
// Pipelined integer square root, one root bit per stage; the world values
// travel alongside.
// ----------------------------------------------------------------------------
module qwam_sqrt (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  qwam_pkg::mag_in_t  in_item,
	output logic               out_valid,
	output qwam_pkg::mag_out_t out_item
);
	import qwam_pkg::*;

	typedef struct packed {
		logic [ROOT_W:0]   rem;
		logic [ROOT_W-1:0] root;
		logic [RAD_W-1:0]  rad;
		logic              big;
		world_t            world;
	} sq_t;

	logic [SQRT_STAGES-1:0] v_s;
	sq_t st_s [SQRT_STAGES];
	sq_t st_in;

	function automatic sq_t sq_step(input sq_t s);
		logic [ROOT_W+2:0] r;
		logic [ROOT_W+2:0] trial;
		logic [ROOT_W+2:0] diff;
		logic              ge;
		sq_t               o;
		r     = {s.rem, s.rad[RAD_W-1 -: 2]};
		trial = {1'b0, s.root, 2'b01};
		ge    = r >= trial;
		diff  = r - trial;
		o      = s;
		o.rem  = ge ? diff[ROOT_W:0] : r[ROOT_W:0];
		o.root = {s.root[ROOT_W-2:0], ge};
		o.rad  = {s.rad[RAD_W-3:0], 2'b00};
		return o;
	endfunction

	always_comb begin
		st_in.rem   = '0;
		st_in.root  = '0;
		st_in.rad   = in_item.rad;
		st_in.big   = in_item.big;
		st_in.world = in_item.world;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			v_s <= {v_s[SQRT_STAGES-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		st_s[0] <= sq_step(st_in);
		for (int k = 1; k < SQRT_STAGES; k++) begin
			st_s[k] <= sq_step(st_s[k-1]);
		end
	end

	assign out_valid      = v_s[SQRT_STAGES-1];
	assign out_item.root  = st_s[SQRT_STAGES-1].root;
	assign out_item.big   = st_s[SQRT_STAGES-1].big;
	assign out_item.world = st_s[SQRT_STAGES-1].world;

endmodule

// ===== src/quaternion_world_accel_magnitude.sv =====
// ----------------------------------------------------------------------------
// quaternion_world_accel_magnitude
// Rotates a raw accel sample into the world frame (ENU) by a unit quaternion,
// converts to mg, removes 1 g from the up axis, and reports the magnitude in
// tenths of g.
//
//   channel  | signals                | handshake
//   ---------+------------------------+------------------------------------
//   config   | cfg_we, cfg_wdata      | written on any edge with cfg_we high
//   sample   | start, busy, sample    | taken on an edge with start && !busy
//   result   | done, result           | done high for one cycle per item
//
// One item per cycle, every cycle. Its depth is set mostly by the
// 17-stage scale divider and the 16-stage root for the magnitude.
// Reset clears all valid bits and loads the scale with 2048 counts per g.
// There is no backpressure: busy stays low and results are never held.
// ----------------------------------------------------------------------------
module quaternion_world_accel_magnitude #(
	parameter int QUAT_FRAC_BITS = 14
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [15:0]     cfg_wdata,
	input  logic            start,
	output logic            busy,
	input  qwam_pkg::in_t   sample,
	output logic            done,
	output qwam_pkg::out_t  result
);
	import qwam_pkg::*;

	localparam logic signed [18:0] OUT_MAX = 19'sd32767;
	localparam logic signed [18:0] OUT_MIN = -19'sd32768;
	localparam logic signed [18:0] BIG_POS = 19'(MAG_SAT_MG);
	localparam logic signed [18:0] BIG_NEG = -19'(MAG_SAT_MG);
	localparam logic signed [18:0] Z_OFF   = 19'(MG_PER_G);
	localparam logic [15:0]        ROOT_SAT = 16'(MAG_SAT_MG);

	logic [15:0] lsb_q;
	logic [15:0] lsb;
	logic        accept;

	logic            rot_valid;
	div_lane_t [2:0] rot_lanes;
	logic            div_valid;
	div_lane_t [2:0] div_lanes;

	logic                v_s24;
	logic                neg_s24 [3];
	logic                ovf_s24 [3];
	logic signed [18:0]  val_s24 [3];
	logic                v_s25;
	world_t              world_s25;
	logic                big_s25;
	logic [14:0]         abs_s25 [3];
	logic                v_s26;
	world_t              world_s26;
	logic                big_s26;
	logic [29:0]         sq_s26 [3];
	logic                v_s27;
	mag_in_t             mag_s27;

	logic     sq_valid;
	mag_out_t sq_out;

	logic done_s44;
	out_t res_s44;

	logic signed [18:0] fold [3];
	logic signed [18:0] off [3];
	logic signed [15:0] sat_val [3];
	logic               is_big [3];
	logic [14:0]        absv [3];
	logic signed [18:0] negv [3];
	logic [15:0]        tn;
	logic [32:0]        tprod;
	logic [7:0]         tenths;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lsb_q <= LSB_RESET;
		end else if (cfg_we) begin
			lsb_q <= cfg_wdata;
		end
	end

	// zero scale acts as one
	assign lsb    = (lsb_q == 16'd0) ? 16'd1 : lsb_q;
	assign busy   = 1'b0;
	assign accept = start && !busy;

	qwam_rot #(
		.QUAT_FRAC_BITS(QUAT_FRAC_BITS)
	) u_rot (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.in_item  (sample),
		.lsb      (lsb),
		.out_valid(rot_valid),
		.lanes    (rot_lanes)
	);

	qwam_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rot_valid),
		.lsb      (lsb),
		.in_lanes (rot_lanes),
		.out_valid(div_valid),
		.out_lanes(div_lanes)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s24    <= 1'b0;
			v_s25    <= 1'b0;
			v_s26    <= 1'b0;
			v_s27    <= 1'b0;
			done_s44 <= 1'b0;
		end else begin
			v_s24    <= div_valid;
			v_s25    <= v_s24;
			v_s26    <= v_s25;
			v_s27    <= v_s26;
			done_s44 <= sq_valid;
		end
	end

	// signed mg value; up axis loses 1 g
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			fold[i] = div_lanes[i].neg ? ~19'(div_lanes[i].low) : 19'(div_lanes[i].low);
			off[i]  = (div_lanes[i].neg ? 19'sd1 : 19'sd0) - ((i == LANE_Z) ? Z_OFF : 19'sd0);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			neg_s24[i] <= div_lanes[i].neg;
			ovf_s24[i] <= div_lanes[i].ovf;
			val_s24[i] <= fold[i] + off[i];
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (ovf_s24[i]) begin
				sat_val[i] = neg_s24[i] ? 16'sh8000 : 16'sh7fff;
			end else if (val_s24[i] > OUT_MAX) begin
				sat_val[i] = 16'sh7fff;
			end else if (val_s24[i] < OUT_MIN) begin
				sat_val[i] = 16'sh8000;
			end else begin
				sat_val[i] = val_s24[i][15:0];
			end
			is_big[i] = ovf_s24[i] || (val_s24[i] >= BIG_POS) || (val_s24[i] <= BIG_NEG);
			negv[i]   = -val_s24[i];
			if (is_big[i]) begin
				absv[i] = '0;
			end else begin
				absv[i] = val_s24[i][18] ? negv[i][14:0] : val_s24[i][14:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		world_s25.world_x_mg <= sat_val[0];
		world_s25.world_y_mg <= sat_val[1];
		world_s25.world_z_mg <= sat_val[LANE_Z];
		big_s25              <= is_big[0] || is_big[1] || is_big[LANE_Z];
		abs_s25              <= absv;
	end

	always_ff @(posedge clk) begin
		world_s26 <= world_s25;
		big_s26   <= big_s25;
		for (int i = 0; i < 3; i++) begin
			sq_s26[i] <= 30'(abs_s25[i]) * 30'(abs_s25[i]);
		end
	end

	always_ff @(posedge clk) begin
		mag_s27.world <= world_s26;
		mag_s27.big   <= big_s26;
		mag_s27.rad   <= RAD_W'(sq_s26[0]) + RAD_W'(sq_s26[1]) + RAD_W'(sq_s26[2]);
	end

	qwam_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s27),
		.in_item  (mag_s27),
		.out_valid(sq_valid),
		.out_item (sq_out)
	);

	// tenths = floor((root + 50) / 100) by reciprocal, exact below the clamp
	always_comb begin
		tn    = sq_out.root + 16'(TENTHS_HALF);
		tprod = 33'(tn) * 33'(RECIP_100);
		if (sq_out.big || (sq_out.root >= ROOT_SAT)) begin
			tenths = TENTHS_MAX;
		end else begin
			tenths = tprod[RECIP_SHIFT+7:RECIP_SHIFT];
		end
	end

	always_ff @(posedge clk) begin
		res_s44.world_x_mg         <= sq_out.world.world_x_mg;
		res_s44.world_y_mg         <= sq_out.world.world_y_mg;
		res_s44.world_z_mg         <= sq_out.world.world_z_mg;
		res_s44.magnitude_tenths_g <= tenths;
	end

	assign done   = done_s44;
	assign result = res_s44;

endmodule

// ===== src/qwam_checker.sv =====
// ----------------------------------------------------------------------------
// qwam_checker
// Port-level checks on result timing and on magnitude versus world values.
// ----------------------------------------------------------------------------
`include "quaternion_world_accel_magnitude_macros.svh"

module qwam_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input qwam_pkg::out_t result
);
	import qwam_pkg::*;

	logic accept;
	logic sat_seen;
	logic near_zero;

	assign accept = start && !busy;

	assign sat_seen = (result.world_x_mg == 16'sh7fff) || (result.world_x_mg == 16'sh8000) ||
		(result.world_y_mg == 16'sh7fff) || (result.world_y_mg == 16'sh8000) ||
		(result.world_z_mg == 16'sh7fff) || (result.world_z_mg == 16'sh8000);

	assign near_zero = (result.world_x_mg > -16'sd50) && (result.world_x_mg < 16'sd50) &&
		(result.world_y_mg > -16'sd50) && (result.world_y_mg < 16'sd50) &&
		(result.world_z_mg > -16'sd50) && (result.world_z_mg < 16'sd50);

	`QWAM_ASSERT_DLY(a_result_follows, accept, LATENCY, done, "accepted item gave no result")
	`QWAM_ASSERT_IMP(a_no_orphan, done, $past(accept, LATENCY), "result without an item")
	`QWAM_ASSERT_IMP(a_sat_mag, done && sat_seen, result.magnitude_tenths_g == TENTHS_MAX, "saturated axis without full magnitude")
	`QWAM_ASSERT_IMP(a_zero_mag, done && (result.magnitude_tenths_g == 8'd0), near_zero, "zero magnitude with a large axis")

endmodule

bind quaternion_world_accel_magnitude qwam_checker u_qwam_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.result(result)
);
